### design/nrpt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants for the node registry and presence tracker.
// Holds command and result codes and the controller/datapath interface structs.
// No dependencies.
package nrpt_pkg;

    localparam int ID_W   = 8;
    localparam int DEV_W  = 32;
    localparam int TIME_W = 32;
    localparam int OFF_W  = 5;

    localparam logic [ID_W-1:0]   ID_FREE       = 8'hFF;
    localparam logic [ID_W-1:0]   ID_SELF       = 8'h00;
    localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd60000;

    typedef enum logic [1:0] {
        CMD_JOIN  = 2'd0,
        CMD_HEARD = 2'd1,
        CMD_SWEEP = 2'd2,
        CMD_QUERY = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        JRES_KNOWN = 2'd0,
        JRES_NEW   = 2'd1,
        JRES_FULL  = 2'd2,
        JRES_NONE  = 2'd3
    } t_jres;

    typedef struct packed {
        logic load;
        logic scan_clr;
        logic scan_reg;
        logic ref_act;
        logic reg_act;
        logic sweep_act;
        logic query_act;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        t_cmd cmd;
        logic key_ok;
        logic p_hit;
        logic r_hit;
        logic exh;
        logic out_free;
    } t_dp_stat;

endpackage
`default_nettype wire

### design/nrpt_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
module nrpt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

### design/nrpt_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// Datapath: registry and presence memories, fill counts, scan index and result register.
// Depends on nrpt_pkg and nrpt_ram.
module nrpt_datapath import nrpt_pkg::*; #(
    parameter int NODE_SLOTS = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_dp_cmd           i_cmd,
    output t_dp_stat               o_stat,
    input  wire logic [TIME_W-1:0] i_timeout,
    input  wire logic [1:0]        i_in_cmd,
    input  wire logic [ID_W-1:0]   i_in_src,
    input  wire logic [DEV_W-1:0]  i_in_dev,
    input  wire logic [TIME_W-1:0] i_in_time,
    output logic                   o_out_vld,
    input  wire logic              i_out_rdy,
    output logic [ID_W-1:0]        o_assigned_id,
    output logic [1:0]             o_join_result,
    output logic                   o_came_online,
    output logic                   o_tracker_full,
    output logic [OFF_W-1:0]       o_offline_count,
    output logic                   o_is_online,
    output logic [TIME_W-1:0]      o_last_seen
);

    localparam int IW = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;
    localparam int CW = $clog2(NODE_SLOTS + 1);
    localparam int PW = TIME_W + 1 + ID_W;
    localparam logic [CW-1:0] SLOTS = CW'(NODE_SLOTS);

    t_cmd              r_cmd;
    logic [ID_W-1:0]   r_key,      n_key;
    logic [DEV_W-1:0]  r_dev;
    logic [TIME_W-1:0] r_now;
    logic [CW-1:0]     r_idx,      n_idx;
    logic [IW-1:0]     r_lag_idx;
    logic              r_lag_vld,  n_lag_vld;
    logic [CW-1:0]     r_pcnt,     n_pcnt;
    logic [CW-1:0]     r_rcnt,     n_rcnt;
    logic [ID_W-1:0]   r_assigned, n_assigned;
    t_jres             r_jres,     n_jres;
    logic              r_rose,     n_rose;
    logic              r_full,     n_full;
    logic [OFF_W-1:0]  r_offcnt,   n_offcnt;
    logic              r_online,   n_online;
    logic [TIME_W-1:0] r_seen,     n_seen;
    logic              r_out_vld,  n_out_vld;

    logic [ID_W-1:0]   r_out_assigned;
    t_jres             r_out_jres;
    logic              r_out_rose;
    logic              r_out_full;
    logic [OFF_W-1:0]  r_out_offcnt;
    logic              r_out_online;
    logic [TIME_W-1:0] r_out_seen;

    logic              p_we;
    logic [IW-1:0]     p_waddr;
    logic [PW-1:0]     p_wdata;
    logic [PW-1:0]     p_rdata;
    logic              g_we;
    logic [DEV_W-1:0]  g_rdata;
    logic [ID_W-1:0]   p_node;
    logic              p_online;
    logic [TIME_W-1:0] p_seen;
    logic              p_hit;
    logic              g_hit;
    logic              issue;
    logic              stale;
    logic [CW-1:0]     limit;

    nrpt_ram #(.WIDTH(PW), .DEPTH(NODE_SLOTS)) u_pres_ram (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (p_waddr),
        .i_wdata (p_wdata),
        .i_raddr (r_idx[IW-1:0]),
        .o_rdata (p_rdata)
    );

    // Short IDs are granted in order 1, 2, 3, ... and never released, so the
    // ID of registry entry k is always k + 1 and only the device ID is stored.
    nrpt_ram #(.WIDTH(DEV_W), .DEPTH(NODE_SLOTS)) u_reg_ram (
        .i_clk   (i_clk),
        .i_we    (g_we),
        .i_waddr (r_rcnt[IW-1:0]),
        .i_wdata (r_dev),
        .i_raddr (r_idx[IW-1:0]),
        .o_rdata (g_rdata)
    );

    assign p_node   = p_rdata[ID_W-1:0];
    assign p_online = p_rdata[ID_W];
    assign p_seen   = p_rdata[PW-1:ID_W+1];
    assign p_hit    = r_lag_vld && (p_node == r_key);
    assign g_hit    = r_lag_vld && (g_rdata == r_dev);
    assign limit    = i_cmd.scan_reg ? r_rcnt : r_pcnt;
    assign issue    = (r_idx < limit);
    assign stale    = p_online && ((r_now - p_seen) > i_timeout);

    always_comb begin
        n_key      = r_key;
        n_idx      = r_idx;
        n_lag_vld  = issue;
        n_pcnt     = r_pcnt;
        n_rcnt     = r_rcnt;
        n_assigned = r_assigned;
        n_jres     = r_jres;
        n_rose     = r_rose;
        n_full     = r_full;
        n_offcnt   = r_offcnt;
        n_online   = r_online;
        n_seen     = r_seen;
        n_out_vld  = r_out_vld;
        p_we       = 1'b0;
        p_waddr    = r_lag_idx;
        p_wdata    = {r_now, 1'b1, r_key};
        g_we       = 1'b0;

        if (issue) begin
            n_idx = r_idx + CW'(1);
        end
        if (i_cmd.scan_clr) begin
            n_idx     = '0;
            n_lag_vld = 1'b0;
        end

        if (i_cmd.load) begin
            n_key      = i_in_src;
            n_assigned = ID_FREE;
            n_jres     = JRES_NONE;
            n_rose     = 1'b0;
            n_full     = 1'b0;
            n_offcnt   = '0;
            n_online   = 1'b0;
            n_seen     = '0;
        end

        if (i_cmd.ref_act) begin
            if (p_hit) begin
                p_we   = 1'b1;
                n_rose = r_rose | ~p_online;
            end else if (r_pcnt < SLOTS) begin
                p_we    = 1'b1;
                p_waddr = r_pcnt[IW-1:0];
                n_rose  = 1'b1;
                n_pcnt  = r_pcnt + CW'(1);
            end else begin
                n_full = 1'b1;
            end
        end

        if (i_cmd.reg_act) begin
            if (g_hit) begin
                n_assigned = ID_W'(r_lag_idx) + ID_W'(1);
                n_key      = ID_W'(r_lag_idx) + ID_W'(1);
                n_jres     = JRES_KNOWN;
            end else if (r_rcnt < SLOTS) begin
                g_we       = 1'b1;
                n_rcnt     = r_rcnt + CW'(1);
                n_assigned = ID_W'(r_rcnt) + ID_W'(1);
                n_key      = ID_W'(r_rcnt) + ID_W'(1);
                n_jres     = JRES_NEW;
            end else begin
                n_key  = ID_FREE;
                n_jres = JRES_FULL;
            end
        end

        if (i_cmd.sweep_act && r_lag_vld && stale) begin
            p_we     = 1'b1;
            p_wdata  = {p_seen, 1'b0, p_node};
            n_offcnt = r_offcnt + OFF_W'(1);
        end

        if (i_cmd.query_act && p_hit) begin
            n_online = p_online;
            n_seen   = p_seen;
        end

        if (i_cmd.out_load) begin
            n_out_vld = 1'b1;
        end else if (i_out_rdy) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_lag_vld <= 1'b0;
            r_pcnt    <= '0;
            r_rcnt    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_idx     <= n_idx;
            r_lag_vld <= n_lag_vld;
            r_pcnt    <= n_pcnt;
            r_rcnt    <= n_rcnt;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd <= t_cmd'(i_in_cmd);
            r_dev <= i_in_dev;
            r_now <= i_in_time;
        end
        r_key      <= n_key;
        r_lag_idx  <= r_idx[IW-1:0];
        r_assigned <= n_assigned;
        r_jres     <= n_jres;
        r_rose     <= n_rose;
        r_full     <= n_full;
        r_offcnt   <= n_offcnt;
        r_online   <= n_online;
        r_seen     <= n_seen;
        if (i_cmd.out_load) begin
            r_out_assigned <= r_assigned;
            r_out_jres     <= r_jres;
            r_out_rose     <= r_rose;
            r_out_full     <= r_full;
            r_out_offcnt   <= r_offcnt;
            r_out_online   <= r_online;
            r_out_seen     <= r_seen;
        end
    end

    assign o_stat.cmd      = r_cmd;
    assign o_stat.key_ok   = (r_key != ID_FREE) && (r_key != ID_SELF);
    assign o_stat.p_hit    = p_hit;
    assign o_stat.r_hit    = g_hit;
    assign o_stat.exh      = !issue && !r_lag_vld;
    assign o_stat.out_free = !r_out_vld || i_out_rdy;

    assign o_out_vld       = r_out_vld;
    assign o_assigned_id   = r_out_assigned;
    assign o_join_result   = r_out_jres;
    assign o_came_online   = r_out_rose;
    assign o_tracker_full  = r_out_full;
    assign o_offline_count = r_out_offcnt;
    assign o_is_online     = r_out_online;
    assign o_last_seen     = r_out_seen;

    a_pcnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pcnt <= SLOTS)
        else $error("presence fill count exceeds slot count");

    a_rcnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rcnt <= SLOTS)
        else $error("registry fill count exceeds slot count");

    a_pcnt_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_pcnt >= $past(r_pcnt)))
        else $error("presence fill count decreased");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_vld || i_out_rdy))
        else $error("result register loaded while an item is still pending");

endmodule
`default_nettype wire

### design/nrpt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// Controller state machine: sequences the table scans for each command.
// Depends on nrpt_pkg.
module nrpt_ctrl import nrpt_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    output t_dp_cmd       o_cmd,
    input  wire t_dp_stat i_stat
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_CMD   = 8'b0000_0010,
        S_REF1  = 8'b0000_0100,
        S_RSCAN = 8'b0000_1000,
        S_REF2  = 8'b0001_0000,
        S_SWEEP = 8'b0010_0000,
        S_QSCAN = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic   p_fin;

    assign p_fin = !i_stat.key_ok || i_stat.p_hit || i_stat.exh;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CMD;
                end
            end
            S_CMD: begin
                case (i_stat.cmd)
                    CMD_JOIN:  n_state = S_REF1;
                    CMD_HEARD: n_state = S_REF2;
                    CMD_SWEEP: n_state = S_SWEEP;
                    CMD_QUERY: n_state = S_QSCAN;
                    default:   n_state = S_DONE;
                endcase
            end
            S_REF1: begin
                if (p_fin) begin
                    o_cmd.ref_act = i_stat.key_ok;
                    n_state       = S_RSCAN;
                end
            end
            S_RSCAN: begin
                o_cmd.scan_reg = 1'b1;
                if (i_stat.r_hit || i_stat.exh) begin
                    o_cmd.reg_act = 1'b1;
                    n_state       = S_REF2;
                end
            end
            S_REF2: begin
                if (p_fin) begin
                    o_cmd.ref_act = i_stat.key_ok;
                    n_state       = S_DONE;
                end
            end
            S_SWEEP: begin
                o_cmd.sweep_act = 1'b1;
                if (i_stat.exh) begin
                    n_state = S_DONE;
                end
            end
            S_QSCAN: begin
                if (p_fin) begin
                    o_cmd.query_act = i_stat.key_ok;
                    n_state         = S_DONE;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        o_cmd.scan_clr = (n_state != r_state);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> (r_state == S_IDLE) && i_in_valid)
        else $error("item loaded outside idle");

    a_single_act: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.ref_act, o_cmd.reg_act, o_cmd.sweep_act, o_cmd.query_act,
                  o_cmd.out_load, o_cmd.load}))
        else $error("more than one datapath action in one cycle");

    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> (r_state == S_IDLE))
        else $error("result delivered without returning to idle");

endmodule
`default_nettype wire

### design/node_registry_presence_tracker_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Top level of the node registry and presence tracker: stream ports, APB register
// port and the controller/datapath pair. Depends on nrpt_pkg, nrpt_ctrl, nrpt_datapath.
//
// One command item is taken at a time and yields one result item. Each command walks
// the presence or registry memory one entry per cycle through its single read port,
// and a scan ends at a match or after the last filled entry. A join scans presence,
// registry and presence again. While a finished result waits in the output register,
// the next item is already accepted; its result then waits in the datapath while the
// controller holds in its done state until the output register is free, and no
// further item is taken meanwhile.
// Memories need no clearing pass after reset; fill counts mark the written entries.
module node_registry_presence_tracker_top import nrpt_pkg::*; #(
    parameter int NODE_SLOTS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // source_node_id [7:0], device_id [39:8], current_time [71:40]
    input  wire logic [71:0] i_s_tdata,
    // cmd [1:0]
    input  wire logic [1:0]  i_s_tuser,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // assigned_id [7:0], join_result [9:8], came_online [10], tracker_full [11],
    // offline_count [16:12], is_online [17], last_seen [49:18], zero [55:50]
    output logic [55:0]      o_m_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam logic ADDR_TIMEOUT = 1'b0;

    logic [TIME_W-1:0] r_timeout;
    t_dp_cmd           dp_cmd;
    t_dp_stat          dp_stat;
    logic [ID_W-1:0]   out_assigned;
    logic [1:0]        out_jres;
    logic              out_rose;
    logic              out_full;
    logic [OFF_W-1:0]  out_offcnt;
    logic              out_online;
    logic [TIME_W-1:0] out_seen;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == ADDR_TIMEOUT) ? r_timeout : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
        end else if (psel && penable && pwrite && pready && (paddr[2] == ADDR_TIMEOUT)) begin
            r_timeout <= pwdata;
        end
    end

    nrpt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .o_cmd      (dp_cmd),
        .i_stat     (dp_stat)
    );

    nrpt_datapath #(.NODE_SLOTS(NODE_SLOTS)) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_stat          (dp_stat),
        .i_timeout       (r_timeout),
        .i_in_cmd        (i_s_tuser),
        .i_in_src        (i_s_tdata[7:0]),
        .i_in_dev        (i_s_tdata[39:8]),
        .i_in_time       (i_s_tdata[71:40]),
        .o_out_vld       (o_m_tvalid),
        .i_out_rdy       (i_m_tready),
        .o_assigned_id   (out_assigned),
        .o_join_result   (out_jres),
        .o_came_online   (out_rose),
        .o_tracker_full  (out_full),
        .o_offline_count (out_offcnt),
        .o_is_online     (out_online),
        .o_last_seen     (out_seen)
    );

    assign o_m_tdata = {6'd0, out_seen, out_online, out_offcnt, out_full, out_rose,
                        out_jres, out_assigned};

endmodule
`default_nettype wire
